// ===== sv/asd_pkg.sv =====
// shared types, constants and helpers for the shake and motion detector
// depends on nothing; every other file of the block refers to it by scoped names
package asd_pkg;

	localparam int unsigned CodeW    = 6;
	localparam int unsigned SampleW  = 7;
	localparam int unsigned LevelW   = 8;
	localparam int unsigned ThrW     = 8;
	localparam int unsigned WinW     = 9;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 9;
	localparam int unsigned SumW     = 11;
	localparam int unsigned MaxLevel = 189;

	localparam logic [CodeW-1:0] SignPoint = 6'd32;

	localparam logic [ThrW-1:0] SharpThrRst   = 8'd10;
	localparam logic [WinW-1:0] SharpWinRst   = 9'd5;
	localparam logic [WinW-1:0] SharpCntRst   = 9'd2;
	localparam logic [ThrW-1:0] MoveThrRst    = 8'd5;
	localparam logic [WinW-1:0] MoveWinRst    = 9'd15;
	localparam logic [WinW-1:0] MoveCntRst    = 9'd10;
	localparam logic [WinW-1:0] StillCntRst   = 9'd10;
	localparam logic [WinW-1:0] PeakWinRst    = 9'd60;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SHARP_THRESHOLD = 3'd0,
		REG_SHARP_WINDOW    = 3'd1,
		REG_SHARP_COUNT     = 3'd2,
		REG_MOVE_THRESHOLD  = 3'd3,
		REG_MOVE_WINDOW     = 3'd4,
		REG_MOVE_COUNT      = 3'd5,
		REG_STILL_COUNT     = 3'd6,
		REG_PEAK_WINDOW     = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [CodeW-1:0] accel_x;
		logic [CodeW-1:0] accel_y;
		logic [CodeW-1:0] accel_z;
	} shake_in_t;

	typedef struct packed {
		logic [LevelW-1:0] shake_level;
		logic              sharp_motion;
		logic              is_moving;
		logic              is_motionless;
		logic [LevelW-1:0] window_peak;
	} shake_out_t;

	typedef struct packed {
		logic [ThrW-1:0] sharp_threshold;
		logic [WinW-1:0] sharp_window;
		logic [WinW-1:0] sharp_count;
		logic [ThrW-1:0] move_threshold;
		logic [WinW-1:0] move_window;
		logic [WinW-1:0] move_count;
		logic [WinW-1:0] still_count;
		logic [WinW-1:0] peak_window;
	} cfg_t;

	typedef struct packed {
		logic push;
		logic rotate;
	} chain_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scan_stat_t;

	typedef struct packed {
		logic              sharp;
		logic              moving;
		logic              still;
		logic [LevelW-1:0] peak;
	} scan_res_t;

	// codes above 32 wrap to negative, 32 itself stays positive
	function automatic logic signed [SampleW-1:0] to_signed7(input logic [CodeW-1:0] code);
		logic signed [SampleW-1:0] s;
		s = (code > SignPoint) ? {1'b1, code} : {1'b0, code};
		return s;
	endfunction

endpackage

// ===== sv/asd_cell.sv =====
// one history cell: holds a shake level, shifts toward older on push, rotates on scan
// depends on asd_pkg
module asd_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  asd_pkg::chain_ctrl_t             ctrl,
	input  logic [asd_pkg::LevelW-1:0]       from_prev,
	input  logic [asd_pkg::LevelW-1:0]       from_next,
	output logic [asd_pkg::LevelW-1:0]       value_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (ctrl.push) begin
			value_q <= from_prev;
		end else if (ctrl.rotate) begin
			value_q <= from_next;
		end
	end

endmodule

// ===== sv/asd_level.sv =====
// front end: signed conversion, change against previous sample, running mean
// depends on asd_pkg; three register stages from accepted word to level
module asd_level #(
	parameter int unsigned AverageDepth = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  asd_pkg::shake_in_t         word,
	output logic                       level_valid_s3,
	output logic [asd_pkg::LevelW-1:0] level_s3
);

	localparam int unsigned SlotW       = (AverageDepth > 1) ? $clog2(AverageDepth) : 1;
	localparam int unsigned RecipShift  = asd_pkg::SumW + 3;
	localparam int unsigned RecipW      = RecipShift + 1;
	localparam logic [RecipW-1:0] Recip =
		RecipW'(((1 << RecipShift) + AverageDepth - 1) / AverageDepth);
	localparam int unsigned ProdW       = asd_pkg::SumW + RecipW;

	logic signed [asd_pkg::SampleW-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [asd_pkg::SampleW-1:0] cur_x, cur_y, cur_z;
	logic signed [asd_pkg::SampleW:0]   dx, dy, dz;
	logic [asd_pkg::SampleW-1:0]        ax, ay, az;
	logic [asd_pkg::LevelW-1:0]         change;
	logic [asd_pkg::LevelW-1:0]         ring_q [AverageDepth];
	logic [SlotW-1:0]                   slot_q, slot_n;
	logic                               v_s1, v_s2;
	logic [asd_pkg::SumW-1:0]           sum_s2, ring_sum;
	logic [ProdW-1:0]                   prod;

	always_comb begin
		cur_x  = asd_pkg::to_signed7(word.accel_x);
		cur_y  = asd_pkg::to_signed7(word.accel_y);
		cur_z  = asd_pkg::to_signed7(word.accel_z);
		dx     = {cur_x[asd_pkg::SampleW-1], cur_x} - {prev_x_q[asd_pkg::SampleW-1], prev_x_q};
		dy     = {cur_y[asd_pkg::SampleW-1], cur_y} - {prev_y_q[asd_pkg::SampleW-1], prev_y_q};
		dz     = {cur_z[asd_pkg::SampleW-1], cur_z} - {prev_z_q[asd_pkg::SampleW-1], prev_z_q};
		ax     = dx[asd_pkg::SampleW] ? asd_pkg::SampleW'(-dx) : asd_pkg::SampleW'(dx);
		ay     = dy[asd_pkg::SampleW] ? asd_pkg::SampleW'(-dy) : asd_pkg::SampleW'(dy);
		az     = dz[asd_pkg::SampleW] ? asd_pkg::SampleW'(-dz) : asd_pkg::SampleW'(dz);
		change = asd_pkg::LevelW'(ax) + asd_pkg::LevelW'(ay) + asd_pkg::LevelW'(az);
		slot_n = (slot_q == SlotW'(AverageDepth - 1)) ? '0 : slot_q + 1'b1;
	end

	always_comb begin
		ring_sum = '0;
		for (int i = 0; i < AverageDepth; i++) begin
			ring_sum = ring_sum + asd_pkg::SumW'(ring_q[i]);
		end
	end

	assign prod = ProdW'(sum_s2) * ProdW'(Recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			prev_z_q       <= '0;
			slot_q         <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			level_valid_s3 <= 1'b0;
			for (int i = 0; i < AverageDepth; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			v_s1           <= take;
			v_s2           <= v_s1;
			level_valid_s3 <= v_s2;
			if (take) begin
				prev_x_q       <= cur_x;
				prev_y_q       <= cur_y;
				prev_z_q       <= cur_z;
				slot_q         <= slot_n;
				ring_q[slot_n] <= change;
			end
		end
	end

	// mean by reciprocal multiply, exact for every reachable sum
	always_ff @(posedge clk) begin
		if (v_s1) begin
			sum_s2 <= ring_sum;
		end
		if (v_s2) begin
			level_s3 <= prod[RecipShift +: asd_pkg::LevelW];
		end
	end

endmodule

// ===== sv/asd_scan.sv =====
// scan unit: watches the head cell while the history rotates once, counts and tracks the peak
// depends on asd_pkg
module asd_scan #(
	parameter int unsigned HistoryDepth = 300
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [asd_pkg::LevelW-1:0] head,
	input  asd_pkg::cfg_t              cfg,
	output asd_pkg::scan_stat_t        stat,
	output asd_pkg::scan_res_t         res
);

	localparam int unsigned IdxW   = $clog2(HistoryDepth);
	localparam int unsigned CntW   = $clog2(HistoryDepth + 1);
	localparam int unsigned CmpW   = (IdxW > asd_pkg::WinW) ? IdxW : asd_pkg::WinW;
	localparam int unsigned CntCmpW = (CntW > asd_pkg::WinW) ? CntW : asd_pkg::WinW;

	logic                       busy_q, done_q;
	logic [IdxW-1:0]            idx_q;
	logic [CntW-1:0]            sharp_cnt_q, move_cnt_q, still_cnt_q;
	logic [asd_pkg::LevelW-1:0] peak_q;
	logic                       last, in_sharp, in_move, in_peak;
	logic                       over_sharp, over_move;

	always_comb begin
		last       = (idx_q == IdxW'(HistoryDepth - 1));
		in_sharp   = CmpW'(idx_q) < CmpW'(cfg.sharp_window);
		in_move    = CmpW'(idx_q) < CmpW'(cfg.move_window);
		in_peak    = CmpW'(idx_q) < CmpW'(cfg.peak_window);
		over_sharp = head > cfg.sharp_threshold;
		over_move  = head > cfg.move_threshold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				busy_q <= !last;
				idx_q  <= last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sharp_cnt_q <= '0;
			move_cnt_q  <= '0;
			still_cnt_q <= '0;
			peak_q      <= '0;
		end else if (busy_q) begin
			if (in_sharp && over_sharp) begin
				sharp_cnt_q <= sharp_cnt_q + 1'b1;
			end
			if (in_move && over_move) begin
				move_cnt_q <= move_cnt_q + 1'b1;
			end
			if (over_move) begin
				still_cnt_q <= still_cnt_q + 1'b1;
			end
			if (in_peak && head > peak_q) begin
				peak_q <= head;
			end
		end
	end

	always_comb begin
		stat.busy  = busy_q;
		stat.done  = done_q;
		res.sharp  = CntCmpW'(sharp_cnt_q) >= CntCmpW'(cfg.sharp_count);
		res.moving = CntCmpW'(move_cnt_q) >= CntCmpW'(cfg.move_count);
		res.still  = CntCmpW'(still_cnt_q) < CntCmpW'(cfg.still_count);
		res.peak   = peak_q;
	end

endmodule

// ===== sv/accel_shake_motion_detector_core.sv =====
// top level of the shake and motion detector: control, config registers, history chain
// depends on asd_pkg, asd_level, asd_cell and asd_scan
//
// One sample word is taken at a time and gives one result word. A word passes three
// register stages to form the averaged shake level, which is pushed into a chain of
// HistoryDepth cells; the chain then rotates once around while the scan unit reads the
// newest cell, and the result is loaded after that full rotation ends. The next word
// can be taken once the result is loaded. The result sits in an output register, so
// the next sample is taken while it waits. History, averaging ring and previous sample
// clear at the asynchronous reset. Config writes are taken at any time but belong
// between words.
module accel_shake_motion_detector_core #(
	parameter int unsigned HistoryDepth = 300,
	parameter int unsigned AverageDepth = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  asd_pkg::shake_in_t            sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output asd_pkg::shake_out_t           result,
	input  logic                          cfg_we,
	input  logic [asd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [asd_pkg::CfgDataW-1:0]  cfg_data
);

	asd_pkg::state_t            state_q, state_n;
	asd_pkg::cfg_t              cfg_q;
	asd_pkg::chain_ctrl_t       chain_ctrl;
	asd_pkg::scan_stat_t        scan_stat;
	asd_pkg::scan_res_t         scan_res;
	asd_pkg::shake_out_t        result_q;
	logic                       result_valid_q;
	logic                       take, level_valid, scan_start, load, out_free;
	logic [asd_pkg::LevelW-1:0] level;
	logic [asd_pkg::LevelW-1:0] tap [HistoryDepth];

	assign take     = sample_valid && !sample_stall;
	assign out_free = !result_valid_q || !result_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sharp_threshold <= asd_pkg::SharpThrRst;
			cfg_q.sharp_window    <= asd_pkg::SharpWinRst;
			cfg_q.sharp_count     <= asd_pkg::SharpCntRst;
			cfg_q.move_threshold  <= asd_pkg::MoveThrRst;
			cfg_q.move_window     <= asd_pkg::MoveWinRst;
			cfg_q.move_count      <= asd_pkg::MoveCntRst;
			cfg_q.still_count     <= asd_pkg::StillCntRst;
			cfg_q.peak_window     <= asd_pkg::PeakWinRst;
		end else if (cfg_we) begin
			unique case (asd_pkg::cfg_idx_t'(cfg_index))
				asd_pkg::REG_SHARP_THRESHOLD: cfg_q.sharp_threshold <= cfg_data[asd_pkg::ThrW-1:0];
				asd_pkg::REG_SHARP_WINDOW:    cfg_q.sharp_window    <= cfg_data;
				asd_pkg::REG_SHARP_COUNT:     cfg_q.sharp_count     <= cfg_data;
				asd_pkg::REG_MOVE_THRESHOLD:  cfg_q.move_threshold  <= cfg_data[asd_pkg::ThrW-1:0];
				asd_pkg::REG_MOVE_WINDOW:     cfg_q.move_window     <= cfg_data;
				asd_pkg::REG_MOVE_COUNT:      cfg_q.move_count      <= cfg_data;
				asd_pkg::REG_STILL_COUNT:     cfg_q.still_count     <= cfg_data;
				asd_pkg::REG_PEAK_WINDOW:     cfg_q.peak_window     <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			asd_pkg::ST_IDLE:   if (sample_valid) state_n = asd_pkg::ST_LEVEL;
			asd_pkg::ST_LEVEL:  if (level_valid) state_n = asd_pkg::ST_SCAN;
			asd_pkg::ST_SCAN:   if (scan_stat.done) state_n = asd_pkg::ST_FINISH;
			asd_pkg::ST_FINISH: if (out_free) state_n = asd_pkg::ST_IDLE;
			default:            state_n = asd_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		sample_stall      = 1'b1;
		scan_start        = 1'b0;
		load              = 1'b0;
		unique case (state_q)
			asd_pkg::ST_IDLE:   sample_stall = 1'b0;
			asd_pkg::ST_LEVEL:  scan_start   = level_valid;
			asd_pkg::ST_SCAN:   ;
			asd_pkg::ST_FINISH: load         = out_free;
			default:            ;
		endcase
		chain_ctrl.push   = scan_start;
		chain_ctrl.rotate = scan_stat.busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= asd_pkg::ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.shake_level   <= level;
			result_q.sharp_motion  <= scan_res.sharp;
			result_q.is_moving     <= scan_res.moving;
			result_q.is_motionless <= scan_res.still;
			result_q.window_peak   <= scan_res.peak;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	asd_level #(
		.AverageDepth(AverageDepth)
	) u_level (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.word          (sample),
		.level_valid_s3(level_valid),
		.level_s3      (level)
	);

	// history chain: cell 0 holds the newest level
	for (genvar i = 0; i < HistoryDepth; i++) begin : g_cell
		logic [asd_pkg::LevelW-1:0] prev_v, next_v;
		if (i == 0) begin : g_first
			assign prev_v = level;
		end else begin : g_mid
			assign prev_v = tap[i-1];
		end
		if (i == HistoryDepth - 1) begin : g_wrap
			assign next_v = tap[0];
		end else begin : g_link
			assign next_v = tap[i+1];
		end
		asd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (chain_ctrl),
			.from_prev(prev_v),
			.from_next(next_v),
			.value_q  (tap[i])
		);
	end

	asd_scan #(
		.HistoryDepth(HistoryDepth)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scan_start),
		.head  (tap[0]),
		.cfg   (cfg_q),
		.stat  (scan_stat),
		.res   (scan_res)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		scan_stat.busy |-> state_q == asd_pkg::ST_SCAN)
		else $error("scan running outside scan state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("second word taken while one is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == asd_pkg::ST_FINISH)
		else $error("result raised without a finished scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> result.shake_level <= asd_pkg::LevelW'(asd_pkg::MaxLevel))
		else $error("shake level out of range");

endmodule

// ===== tb/sv/asd_shake_checker.sv =====
`timescale 1ns / 100ps
// checker for the shake and motion detector: watches both word channels and the config port,
// keeps its own copy of the shake history and flags, and compares every result word
// depends on asd_pkg for the word, config and register index types
module asd_shake_checker #(
	parameter int unsigned HistDepth = 300,
	parameter int unsigned AvgDepth  = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	input  logic                          sample_stall,
	input  asd_pkg::shake_in_t            sample,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  asd_pkg::shake_out_t           result,
	input  logic                          cfg_we,
	input  logic [asd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [asd_pkg::CfgDataW-1:0]  cfg_data,
	output int                            fail_count,
	output int                            pending_words
);

	int                         prev_x, prev_y, prev_z;
	int                         change_ring [AvgDepth];
	int                         ring_slot;
	logic [asd_pkg::LevelW-1:0] level_hist [HistDepth];
	int                         hist_head;
	asd_pkg::cfg_t              regs;
	asd_pkg::shake_out_t        tick_results [$];
	int                         mismatches;

	function automatic int signed_code(input logic [asd_pkg::CodeW-1:0] c);
		return (c > 6'd32) ? int'(c) - 64 : int'(c);
	endfunction

	function automatic int abs_int(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp_win(input int w);
		return (w > int'(HistDepth)) ? int'(HistDepth) : w;
	endfunction

	function automatic int newest(input int k);
		return int'(level_hist[(hist_head + HistDepth - 1 - k) % HistDepth]);
	endfunction

	function automatic int count_over(input int thr, input int win);
		int n;
		int c;
		n = clamp_win(win);
		c = 0;
		for (int k = 0; k < n; k++) begin
			if (newest(k) > thr)
				c++;
		end
		return c;
	endfunction

	function automatic int peak_over(input int win);
		int n;
		int m;
		n = clamp_win(win);
		m = 0;
		for (int k = 0; k < n; k++) begin
			if (newest(k) > m)
				m = newest(k);
		end
		return m;
	endfunction

	task automatic clear_state();
		prev_x = 0;
		prev_y = 0;
		prev_z = 0;
		for (int i = 0; i < AvgDepth; i++)
			change_ring[i] = 0;
		ring_slot = 0;
		for (int i = 0; i < HistDepth; i++)
			level_hist[i] = '0;
		hist_head = 0;
		regs.sharp_threshold = asd_pkg::SharpThrRst;
		regs.sharp_window    = asd_pkg::SharpWinRst;
		regs.sharp_count     = asd_pkg::SharpCntRst;
		regs.move_threshold  = asd_pkg::MoveThrRst;
		regs.move_window     = asd_pkg::MoveWinRst;
		regs.move_count      = asd_pkg::MoveCntRst;
		regs.still_count     = asd_pkg::StillCntRst;
		regs.peak_window     = asd_pkg::PeakWinRst;
		tick_results.delete();
	endtask

	task automatic predict_tick(input asd_pkg::shake_in_t w);
		int sx, sy, sz;
		int change;
		int sum;
		int lvl;
		asd_pkg::shake_out_t r;
		sx = signed_code(w.accel_x);
		sy = signed_code(w.accel_y);
		sz = signed_code(w.accel_z);
		change = abs_int(sx - prev_x) + abs_int(sy - prev_y) + abs_int(sz - prev_z);
		prev_x = sx;
		prev_y = sy;
		prev_z = sz;
		ring_slot = (ring_slot + 1) % AvgDepth;
		change_ring[ring_slot] = change;
		sum = 0;
		for (int i = 0; i < AvgDepth; i++)
			sum += change_ring[i];
		lvl = sum / AvgDepth;
		level_hist[hist_head] = asd_pkg::LevelW'(lvl);
		hist_head = (hist_head + 1) % HistDepth;
		r.shake_level   = asd_pkg::LevelW'(lvl);
		r.sharp_motion  = count_over(int'(regs.sharp_threshold), int'(regs.sharp_window))
			>= int'(regs.sharp_count);
		r.is_moving     = count_over(int'(regs.move_threshold), int'(regs.move_window))
			>= int'(regs.move_count);
		r.is_motionless = count_over(int'(regs.move_threshold), HistDepth)
			< int'(regs.still_count);
		r.window_peak   = asd_pkg::LevelW'(peak_over(int'(regs.peak_window)));
		tick_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [asd_pkg::LevelW-1:0] got,
			input logic [asd_pkg::LevelW-1:0] want);
		mismatches++;
		$display("%0t shake check: %s got %0d want %0d", $realtime, what, got, want);
	endtask

	task automatic check_word(input asd_pkg::shake_out_t got);
		asd_pkg::shake_out_t want;
		if (tick_results.size() == 0) begin
			report_mismatch("result word with nothing pending", got.shake_level, '0);
		end else begin
			want = tick_results.pop_front();
			if (got.shake_level !== want.shake_level)
				report_mismatch("shake_level", got.shake_level, want.shake_level);
			if (got.sharp_motion !== want.sharp_motion)
				report_mismatch("sharp_motion", asd_pkg::LevelW'(got.sharp_motion),
					asd_pkg::LevelW'(want.sharp_motion));
			if (got.is_moving !== want.is_moving)
				report_mismatch("is_moving", asd_pkg::LevelW'(got.is_moving),
					asd_pkg::LevelW'(want.is_moving));
			if (got.is_motionless !== want.is_motionless)
				report_mismatch("is_motionless", asd_pkg::LevelW'(got.is_motionless),
					asd_pkg::LevelW'(want.is_motionless));
			if (got.window_peak !== want.window_peak)
				report_mismatch("window_peak", got.window_peak, want.window_peak);
		end
	endtask

	initial begin
		mismatches = 0;
		fail_count = 0;
		pending_words = 0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (cfg_we) begin
				case (asd_pkg::cfg_idx_t'(cfg_index))
					asd_pkg::REG_SHARP_THRESHOLD:
						regs.sharp_threshold = cfg_data[asd_pkg::ThrW-1:0];
					asd_pkg::REG_SHARP_WINDOW:    regs.sharp_window    = cfg_data;
					asd_pkg::REG_SHARP_COUNT:     regs.sharp_count     = cfg_data;
					asd_pkg::REG_MOVE_THRESHOLD:
						regs.move_threshold  = cfg_data[asd_pkg::ThrW-1:0];
					asd_pkg::REG_MOVE_WINDOW:     regs.move_window     = cfg_data;
					asd_pkg::REG_MOVE_COUNT:      regs.move_count      = cfg_data;
					asd_pkg::REG_STILL_COUNT:     regs.still_count     = cfg_data;
					asd_pkg::REG_PEAK_WINDOW:     regs.peak_window     = cfg_data;
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall)
				predict_tick(sample);
			if (result_valid && !result_stall)
				check_word(result);
		end
		fail_count    <= mismatches;
		pending_words <= tick_results.size();
	end

endmodule

// ===== tb/sv/tb_accel_shake_motion_detector_core.sv =====
`timescale 1ns / 100ps
// top of the shake and motion detector testbench: clock, reset, sample and config stimulus,
// result stalls, watchdog and verdict; checking is done by asd_shake_checker
// depends on asd_pkg, asd_shake_checker and accel_shake_motion_detector_core
module tb_accel_shake_motion_detector_core;

	localparam int HistDepth   = 300;
	localparam int AvgDepth    = 2;
	localparam int ChunkWords  = 200;
	localparam int Chunks      = 8;
	localparam int HoldCycles  = 3000;
	localparam int DrainCycles = 400;
	localparam int StallLimit  = 20000;

	typedef enum int {
		MODE_STILL,
		MODE_JITTER,
		MODE_JUMP
	} motion_mode_t;

	logic                         clk;
	logic                         arst_n;
	logic                         sample_valid;
	logic                         sample_stall;
	asd_pkg::shake_in_t           sample;
	logic                         result_valid;
	logic                         result_stall;
	asd_pkg::shake_out_t          result;
	logic                         cfg_we;
	logic [asd_pkg::CfgIdxW-1:0]  cfg_index;
	logic [asd_pkg::CfgDataW-1:0] cfg_data;

	int                 fail_count;
	int                 pending_words;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 hold_requests;
	int                 holds_done;
	int                 quiet_cycles;
	asd_pkg::shake_in_t last_word;

	accel_shake_motion_detector_core #(
		.HistoryDepth(HistDepth),
		.AverageDepth(AvgDepth)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	asd_shake_checker #(
		.HistDepth(HistDepth),
		.AvgDepth(AvgDepth)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_words(pending_words)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result side: random stalls, plus a long hold whenever one is requested
	initial begin
		result_stall = 1'b0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done < hold_requests) begin
				result_stall <= 1'b1;
				repeat (HoldCycles - 1) @(posedge clk);
				holds_done++;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= StallLimit) begin
			$display("accel_shake_motion_detector_core verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(input asd_pkg::shake_in_t w);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (send_idle_pct > 0 && $urandom_range(0, 49) == 0)
			gap += $urandom_range(0, 350);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= w;
		sample_valid <= 1'b1;
		last_word = w;
		do
			@(posedge clk);
		while (sample_stall);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_words != 0);
	endtask

	task automatic write_reg(input asd_pkg::cfg_idx_t idx,
			input logic [asd_pkg::CfgDataW-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic apply_settings(input asd_pkg::cfg_t c);
		write_reg(asd_pkg::REG_SHARP_THRESHOLD, {1'($urandom_range(0, 1)), c.sharp_threshold});
		write_reg(asd_pkg::REG_SHARP_WINDOW, c.sharp_window);
		write_reg(asd_pkg::REG_SHARP_COUNT, c.sharp_count);
		write_reg(asd_pkg::REG_MOVE_THRESHOLD, {1'($urandom_range(0, 1)), c.move_threshold});
		write_reg(asd_pkg::REG_MOVE_WINDOW, c.move_window);
		write_reg(asd_pkg::REG_MOVE_COUNT, c.move_count);
		write_reg(asd_pkg::REG_STILL_COUNT, c.still_count);
		write_reg(asd_pkg::REG_PEAK_WINDOW, c.peak_window);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [asd_pkg::ThrW-1:0] pick_thr();
		if ($urandom_range(0, 3) == 0)
			return asd_pkg::ThrW'($urandom_range(0, 255));
		return asd_pkg::ThrW'($urandom_range(0, 50));
	endfunction

	function automatic logic [asd_pkg::WinW-1:0] pick_win();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r < 3)
			return asd_pkg::WinW'($urandom_range(301, 511));
		if (r < 12)
			return asd_pkg::WinW'($urandom_range(1, 40));
		return asd_pkg::WinW'($urandom_range(41, 300));
	endfunction

	function automatic logic [asd_pkg::WinW-1:0] pick_count(
			input logic [asd_pkg::WinW-1:0] win);
		int r;
		int lim;
		r = $urandom_range(0, 9);
		lim = (int'(win) > HistDepth) ? HistDepth : int'(win);
		if (r == 0)
			return '0;
		if (r == 1)
			return asd_pkg::WinW'($urandom_range(0, 511));
		return asd_pkg::WinW'($urandom_range(0, lim));
	endfunction

	function automatic asd_pkg::cfg_t random_settings();
		asd_pkg::cfg_t c;
		c.sharp_threshold = pick_thr();
		c.sharp_window    = pick_win();
		c.sharp_count     = pick_count(c.sharp_window);
		c.move_threshold  = pick_thr();
		c.move_window     = pick_win();
		c.move_count      = pick_count(c.move_window);
		c.still_count     = pick_count(9'd300);
		c.peak_window     = pick_win();
		return c;
	endfunction

	function automatic logic [asd_pkg::CodeW-1:0] nudge(input logic [asd_pkg::CodeW-1:0] c,
			input int span);
		int d;
		d = $urandom_range(0, 2 * span) - span;
		return asd_pkg::CodeW'(int'(c) + d + 64);
	endfunction

	function automatic asd_pkg::shake_in_t motion_word(input motion_mode_t mode,
			input asd_pkg::shake_in_t prev);
		asd_pkg::shake_in_t w;
		w = prev;
		case (mode)
			MODE_STILL: begin
				if ($urandom_range(0, 3) == 0)
					w.accel_x = nudge(prev.accel_x, 1);
			end
			MODE_JITTER: begin
				w.accel_x = nudge(prev.accel_x, $urandom_range(1, 6));
				w.accel_y = nudge(prev.accel_y, $urandom_range(1, 6));
				w.accel_z = nudge(prev.accel_z, $urandom_range(1, 6));
			end
			default: begin
				w.accel_x = asd_pkg::CodeW'($urandom_range(0, 63));
				w.accel_y = asd_pkg::CodeW'($urandom_range(0, 63));
				w.accel_z = asd_pkg::CodeW'($urandom_range(0, 63));
			end
		endcase
		return w;
	endfunction

	initial begin
		asd_pkg::cfg_t c;
		motion_mode_t  mode;
		int            run;
		int            sent;
		int            r;

		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_requests = 0;
		send_idle_pct = 30;
		recv_idle_pct = 70;
		last_word = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: sign boundary, largest change, full swings
		send_word(asd_pkg::shake_in_t'{6'd0, 6'd0, 6'd0});
		send_word(asd_pkg::shake_in_t'{6'd32, 6'd32, 6'd32});
		send_word(asd_pkg::shake_in_t'{6'd33, 6'd33, 6'd33});
		send_word(asd_pkg::shake_in_t'{6'd32, 6'd32, 6'd32});
		send_word(asd_pkg::shake_in_t'{6'd33, 6'd33, 6'd33});
		send_word(asd_pkg::shake_in_t'{6'd63, 6'd63, 6'd63});
		send_word(asd_pkg::shake_in_t'{6'd0, 6'd0, 6'd0});
		send_word(asd_pkg::shake_in_t'{6'd1, 6'd2, 6'd3});
		send_word(asd_pkg::shake_in_t'{6'd31, 6'd31, 6'd31});
		send_word(asd_pkg::shake_in_t'{6'd32, 6'd0, 6'd63});
		send_word(asd_pkg::shake_in_t'{6'd33, 6'd63, 6'd0});
		send_word(asd_pkg::shake_in_t'{6'd0, 6'd32, 6'd33});
		repeat (6) send_word(asd_pkg::shake_in_t'{6'd0, 6'd32, 6'd33});
		send_word(asd_pkg::shake_in_t'{6'd16, 6'd48, 6'd8});
		send_word(asd_pkg::shake_in_t'{6'd63, 6'd0, 6'd32});
		send_word(asd_pkg::shake_in_t'{6'd32, 6'd33, 6'd32});
		send_word(asd_pkg::shake_in_t'{6'd42, 6'd21, 6'd63});

		for (int chunk = 0; chunk < Chunks; chunk++) begin
			wait_drained();
			if (chunk < 3) begin
				send_idle_pct = 30;
				recv_idle_pct = 70;
			end else if (chunk < 6) begin
				send_idle_pct = 70;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (chunk)
				1: c = asd_pkg::cfg_t'{sharp_threshold: 8'd0, sharp_window: 9'd0,
					sharp_count: 9'd0, move_threshold: 8'd0, move_window: 9'd0,
					move_count: 9'd0, still_count: 9'd0, peak_window: 9'd0};
				3: c = asd_pkg::cfg_t'{sharp_threshold: 8'd255, sharp_window: 9'd511,
					sharp_count: 9'd511, move_threshold: 8'd255, move_window: 9'd511,
					move_count: 9'd511, still_count: 9'd511, peak_window: 9'd511};
				5: c = asd_pkg::cfg_t'{sharp_threshold: 8'd189, sharp_window: 9'd1,
					sharp_count: 9'd1, move_threshold: 8'd0, move_window: 9'd300,
					move_count: 9'd300, still_count: 9'd300, peak_window: 9'd300};
				default: c = random_settings();
			endcase
			apply_settings(c);

			sent = 0;
			while (sent < ChunkWords) begin
				r = $urandom_range(0, 99);
				mode = (r < 35) ? MODE_STILL : (r < 70) ? MODE_JITTER : MODE_JUMP;
				run = $urandom_range(3, 40);
				for (int k = 0; k < run && sent < ChunkWords; k++) begin
					send_word(motion_word(mode, last_word));
					sent++;
					if ((chunk == 1 || chunk == 4) && sent == 60)
						hold_requests <= hold_requests + 1;
				end
			end
		end

		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("accel_shake_motion_detector_core verification clean");
		else
			$display("accel_shake_motion_detector_core verification failed");
		$finish;
	end

endmodule
